### sv/sfd_pkg.sv
// Shared types and constants of the stereo feedback delay.
// No dependencies; the files that use it refer to it by scoped names.
package sfd_pkg;

	typedef struct packed {
		logic [24:0] delay_time;
		logic [14:0] feedback_gain;
		logic [14:0] dry_gain;
		logic [14:0] wet_gain;
		logic [15:0] drive_gain;
		logic        ping_pong;
		logic [63:0] lowcut_coeffs;
		logic [63:0] highcut_coeffs;
	} cfg_t;

	localparam logic [2:0] REG_DELAY_TIME    = 3'd0;
	localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd1;
	localparam logic [2:0] REG_DRY_GAIN      = 3'd2;
	localparam logic [2:0] REG_WET_GAIN      = 3'd3;
	localparam logic [2:0] REG_DRIVE_GAIN    = 3'd4;
	localparam logic [2:0] REG_PING_PONG     = 3'd5;
	localparam logic [2:0] REG_LOWCUT        = 3'd6;
	localparam logic [2:0] REG_HIGHCUT       = 3'd7;

	localparam logic [24:0] RST_DELAY_TIME    = 25'd4915200;
	localparam logic [14:0] RST_FEEDBACK_GAIN = 15'd11469;
	localparam logic [14:0] RST_DRY_GAIN      = 15'd13969;
	localparam logic [14:0] RST_WET_GAIN      = 15'd8561;
	localparam logic [15:0] RST_DRIVE_GAIN    = 16'd8173;

	localparam logic [14:0] FEEDBACK_CAP = 15'd31129;

	// shared multiplier operand widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 22;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [5:0] TANH_LAST = 6'd32;

	// tanh, Q15, steps of 1/8 from 0 to 4
	function automatic logic [14:0] tanh_lut(input logic [5:0] idx);
		logic [14:0] v;
		case (idx)
			6'd0:  v = 15'd0;
			6'd1:  v = 15'd4075;
			6'd2:  v = 15'd8026;
			6'd3:  v = 15'd11743;
			6'd4:  v = 15'd15143;
			6'd5:  v = 15'd18173;
			6'd6:  v = 15'd20813;
			6'd7:  v = 15'd23066;
			6'd8:  v = 15'd24956;
			6'd9:  v = 15'd26519;
			6'd10: v = 15'd27796;
			6'd11: v = 15'd28830;
			6'd12: v = 15'd29660;
			6'd13: v = 15'd30322;
			6'd14: v = 15'd30847;
			6'd15: v = 15'd31262;
			6'd16: v = 15'd31589;
			6'd17: v = 15'd31846;
			6'd18: v = 15'd32048;
			6'd19: v = 15'd32206;
			6'd20: v = 15'd32329;
			6'd21: v = 15'd32426;
			6'd22: v = 15'd32501;
			6'd23: v = 15'd32560;
			6'd24: v = 15'd32606;
			6'd25: v = 15'd32642;
			6'd26: v = 15'd32670;
			6'd27: v = 15'd32691;
			6'd28: v = 15'd32708;
			6'd29: v = 15'd32721;
			6'd30: v = 15'd32732;
			6'd31: v = 15'd32740;
			default: v = 15'd32746;
		endcase
		return v;
	endfunction

endpackage

### sv/sfd_ifs.sv
// Stream interfaces for the stereo word in and the stereo word out.
// Depends on nothing; widths come from the sample width parameter.
interface sfd_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;
	modport source (output valid, left_in, right_in, input ready);
	modport sink (input valid, left_in, right_in, output ready);
endinterface

interface sfd_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

### sv/sfd_regs.sv
// APB register file holding the static settings of the delay.
// Depends on sfd_pkg for the register struct, indexes and reset values.
module sfd_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	output sfd_pkg::cfg_t cfg
);
	sfd_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign idx    = paddr[5:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_time     <= sfd_pkg::RST_DELAY_TIME;
			cfg_q.feedback_gain  <= sfd_pkg::RST_FEEDBACK_GAIN;
			cfg_q.dry_gain       <= sfd_pkg::RST_DRY_GAIN;
			cfg_q.wet_gain       <= sfd_pkg::RST_WET_GAIN;
			cfg_q.drive_gain     <= sfd_pkg::RST_DRIVE_GAIN;
			cfg_q.ping_pong      <= 1'b0;
			cfg_q.lowcut_coeffs  <= '0;
			cfg_q.highcut_coeffs <= '0;
		end else if (wr) begin
			case (idx)
				sfd_pkg::REG_DELAY_TIME:    cfg_q.delay_time <= pwdata[24:0];
				sfd_pkg::REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= pwdata[14:0];
				sfd_pkg::REG_DRY_GAIN:      cfg_q.dry_gain <= pwdata[14:0];
				sfd_pkg::REG_WET_GAIN:      cfg_q.wet_gain <= pwdata[14:0];
				sfd_pkg::REG_DRIVE_GAIN:    cfg_q.drive_gain <= pwdata[15:0];
				sfd_pkg::REG_PING_PONG:     cfg_q.ping_pong <= pwdata[0];
				sfd_pkg::REG_LOWCUT:        cfg_q.lowcut_coeffs <= pwdata;
				sfd_pkg::REG_HIGHCUT:       cfg_q.highcut_coeffs <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sfd_pkg::REG_DELAY_TIME:    prdata = {39'd0, cfg_q.delay_time};
			sfd_pkg::REG_FEEDBACK_GAIN: prdata = {49'd0, cfg_q.feedback_gain};
			sfd_pkg::REG_DRY_GAIN:      prdata = {49'd0, cfg_q.dry_gain};
			sfd_pkg::REG_WET_GAIN:      prdata = {49'd0, cfg_q.wet_gain};
			sfd_pkg::REG_DRIVE_GAIN:    prdata = {48'd0, cfg_q.drive_gain};
			sfd_pkg::REG_PING_PONG:     prdata = {63'd0, cfg_q.ping_pong};
			sfd_pkg::REG_LOWCUT:        prdata = cfg_q.lowcut_coeffs;
			sfd_pkg::REG_HIGHCUT:       prdata = cfg_q.highcut_coeffs;
			default:                    prdata = '0;
		endcase
	end
endmodule

### sv/sfd_dmem.sv
// Circular delay memory: one stereo word per entry, write pointer and fill mark.
// No package dependency. Entries not yet written read back as zero.
module sfd_dmem #(
	parameter int DELAY_DEPTH = 131072,
	parameter int SAMPLE_BITS = 24,
	parameter int AW          = $clog2(DELAY_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [AW-1:0]            raddr,
	output logic [2*SAMPLE_BITS-1:0] rdata,
	input  logic                     wen,
	input  logic [2*SAMPLE_BITS-1:0] wdata,
	output logic [AW-1:0]            wptr
);
	localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);

	logic [2*SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
	logic [2*SAMPLE_BITS-1:0] rd_q;
	logic                     rvalid_q;
	logic [AW-1:0]            wptr_q;
	logic                     filled_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[wptr_q] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// entries are written in pointer order, so below the pointer or after a wrap means written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			filled_q <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= filled_q || (raddr < wptr_q);
			if (wen) begin
				if (wptr_q == LAST) begin
					wptr_q   <= '0;
					filled_q <= 1'b1;
				end else begin
					wptr_q <= wptr_q + 1'b1;
				end
			end
		end
	end

	assign rdata = rvalid_q ? rd_q : '0;
	assign wptr  = wptr_q;
endmodule

### sv/sfd_core.sv
// Sequencer and shared-multiplier datapath: interpolation, filters, drive, mix.
// Depends on sfd_pkg, the stream interfaces and the delay memory ports.
module sfd_core #(
	parameter int DELAY_DEPTH = 131072,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 21,
	parameter int FRAC_BITS   = 8,
	parameter int AW          = $clog2(DELAY_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sfd_pkg::cfg_t            cfg,
	sfd_in_if.sink                   feed,
	sfd_out_if.source                result,
	output logic [AW-1:0]            mem_raddr,
	input  logic [2*SAMPLE_BITS-1:0] mem_rdata,
	output logic                     mem_wen,
	output logic [2*SAMPLE_BITS-1:0] mem_wdata,
	input  logic [AW-1:0]            mem_wptr
);
	localparam int SB   = SAMPLE_BITS;
	localparam int F    = COEF_BITS - 2;
	localparam int ACCW = 58;
	localparam int CLW  = (FRAC_BITS + AW > 25) ? FRAC_BITS + AW : 25;
	localparam int PW   = sfd_pkg::PROD_W;
	localparam int MAW  = sfd_pkg::MUL_A_W;
	localparam int MBW  = sfd_pkg::MUL_B_W;
	localparam logic [CLW-1:0] DT_LO = CLW'(1) << FRAC_BITS;
	localparam logic [CLW-1:0] DT_HI = CLW'(DELAY_DEPTH - 1) << FRAC_BITS;
	localparam logic [AW:0]    DEPTH_W = (AW+1)'(DELAY_DEPTH);
	localparam logic [AW-1:0]  LAST = AW'(DELAY_DEPTH - 1);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RDA  = 5'd1;
	localparam logic [4:0] ST_RDB  = 5'd2;
	localparam logic [4:0] ST_IA   = 5'd3;
	localparam logic [4:0] ST_IB   = 5'd4;
	localparam logic [4:0] ST_IC   = 5'd5;
	localparam logic [4:0] ST_F0   = 5'd6;
	localparam logic [4:0] ST_F1   = 5'd7;
	localparam logic [4:0] ST_F2   = 5'd8;
	localparam logic [4:0] ST_F3   = 5'd9;
	localparam logic [4:0] ST_F4   = 5'd10;
	localparam logic [4:0] ST_D0   = 5'd11;
	localparam logic [4:0] ST_D1   = 5'd12;
	localparam logic [4:0] ST_D2   = 5'd13;
	localparam logic [4:0] ST_D3   = 5'd14;
	localparam logic [4:0] ST_D4   = 5'd15;
	localparam logic [4:0] ST_D5   = 5'd16;
	localparam logic [4:0] ST_WR   = 5'd17;

	logic [4:0]                st_q;
	logic                      ch_q;
	logic                      hc_q;
	logic [AW-1:0]             ra_q, rb_q;
	logic [FRAC_BITS-1:0]      frac_q;
	logic signed [SB-1:0]      x_q [2];
	logic signed [SB-1:0]      a_q [2];
	logic signed [SB-1:0]      bR_q;
	logic signed [SB-1:0]      d_q [2];
	logic signed [SB-1:0]      wr_q [2];
	logic signed [SB-1:0]      o_q [2];
	logic signed [31:0]        ls1_q [2], ls2_q [2], hs1_q [2], hs2_q [2];
	logic signed [31:0]        y_q;
	logic signed [COEF_BITS+32:0] bx_q;
	logic [14:0]               t0_q;
	logic                      tsat_q;
	logic signed [SB+16:0]     oacc_q;
	logic signed [PW-1:0]      p_q;
	logic                      ov_q;
	logic signed [SB-1:0]      lout_q, rout_q;

	logic signed [MAW-1:0]     ma;
	logic signed [MBW-1:0]     mb;
	logic [CLW-1:0]            dt, dtc;
	logic [AW-1:0]             dint;
	logic [AW:0]               ra_sum;
	logic [AW-1:0]             ra_n, rb_n;
	logic signed [SB-1:0]      rd_l, rd_r;
	logic signed [SB:0]        diff_l, diff_r;
	logic signed [SB-1:0]      fbin;
	logic signed [COEF_BITS-1:0] cb0, ca1, ca2;
	logic signed [31:0]        s1_cur, s2_cur;
	logic signed [ACCW-1:0]    acc;
	logic signed [31:0]        acc_rs;
	logic [31:0]               ymag;
	logic [5:0]                tidx;
	logic                      tover;
	logic [15:0]               f16;
	logic [14:0]               tnext;
	logic [15:0]               tval;
	logic [14:0]               gcap;
	logic [63:0]               fb_sh;
	logic [63:0]               fb_r;
	logic signed [SB+1:0]      fb;
	logic signed [SB+17:0]     wsum;
	logic signed [SB+17:0]     osum;
	logic                      out_free;

	function automatic logic signed [31:0] rsat32(input logic signed [ACCW-1:0] v);
		logic signed [ACCW-1:0] r;
		r = (v + (ACCW'(1) <<< (F - 1))) >>> F;
		if (r > ACCW'(64'sh7FFFFFFF)) begin
			return 32'sh7FFFFFFF;
		end else if (r < -ACCW'(64'sh80000000)) begin
			return -32'sh80000000;
		end
		return r[31:0];
	endfunction

	function automatic logic signed [SB-1:0] satsb(input logic signed [SB+17:0] v);
		logic signed [SB+17:0] hi;
		logic signed [SB+17:0] lo;
		hi = (SB+18)'((1 << (SB - 1)) - 1);
		lo = -hi - 1;
		if (v > hi) begin
			return hi[SB-1:0];
		end else if (v < lo) begin
			return lo[SB-1:0];
		end
		return v[SB-1:0];
	endfunction

	// read addresses of the two taps
	always_comb begin
		dt = CLW'(cfg.delay_time);
		if (dt < DT_LO) begin
			dtc = DT_LO;
		end else if (dt > DT_HI) begin
			dtc = DT_HI;
		end else begin
			dtc = dt;
		end
		dint = dtc[FRAC_BITS +: AW];
		if (mem_wptr >= dint) begin
			ra_sum = {1'b0, mem_wptr} - {1'b0, dint};
		end else begin
			ra_sum = {1'b0, mem_wptr} + DEPTH_W - {1'b0, dint};
		end
		ra_n = ra_sum[AW-1:0];
		rb_n = (ra_n == '0) ? LAST : ra_n - 1'b1;
	end

	assign rd_l   = mem_rdata[SB-1:0];
	assign rd_r   = mem_rdata[2*SB-1:SB];
	assign diff_l = (SB+1)'(rd_l) - (SB+1)'(a_q[0]);
	assign diff_r = (SB+1)'(bR_q) - (SB+1)'(a_q[1]);
	assign fbin   = cfg.ping_pong ? d_q[~ch_q] : d_q[ch_q];

	always_comb begin
		if (hc_q) begin
			cb0 = cfg.highcut_coeffs[COEF_BITS-1:0];
			ca1 = cfg.highcut_coeffs[2*COEF_BITS-1:COEF_BITS];
			ca2 = cfg.highcut_coeffs[3*COEF_BITS-1:2*COEF_BITS];
			s1_cur = hs1_q[ch_q];
			s2_cur = hs2_q[ch_q];
		end else begin
			cb0 = cfg.lowcut_coeffs[COEF_BITS-1:0];
			ca1 = cfg.lowcut_coeffs[2*COEF_BITS-1:COEF_BITS];
			ca2 = cfg.lowcut_coeffs[3*COEF_BITS-1:2*COEF_BITS];
			s1_cur = ls1_q[ch_q];
			s2_cur = ls2_q[ch_q];
		end
	end

	// biquad sums for the filter steps F1, F3 and F4
	always_comb begin
		case (st_q)
			ST_F1: acc = ACCW'(p_q) + (ACCW'(s1_cur) <<< F);
			ST_F3: acc = (hc_q ? (ACCW'(bx_q) <<< 1) : -(ACCW'(bx_q) <<< 1))
				- ACCW'(p_q) + (ACCW'(s2_cur) <<< F);
			ST_F4: acc = ACCW'(bx_q) - ACCW'(p_q);
			default: acc = '0;
		endcase
		acc_rs = rsat32(acc);
	end

	// drive table lookup
	assign ymag  = y_q[31] ? 32'(-y_q) : 32'(y_q);
	assign tover = (p_q >>> (SB + 13)) != '0;
	assign tidx  = {1'b0, p_q[SB+12:SB+8]};
	assign f16   = p_q[SB+7:SB-8];
	assign tnext = sfd_pkg::tanh_lut(tidx + 6'd1);
	assign tval  = tsat_q ? {1'b0, sfd_pkg::tanh_lut(sfd_pkg::TANH_LAST)}
		: 16'(t0_q) + 16'(p_q[31:16]);
	assign gcap  = (cfg.feedback_gain > sfd_pkg::FEEDBACK_CAP) ? sfd_pkg::FEEDBACK_CAP
		: cfg.feedback_gain;

	always_comb begin
		fb_sh = {33'd0, p_q[30:0]} << (SB - 1);
		fb_r  = (fb_sh + (64'd1 << 29)) >> 30;
		fb    = y_q[31] ? -$signed({1'b0, fb_r[SB:0]}) : $signed({1'b0, fb_r[SB:0]});
		wsum  = (SB+18)'(x_q[ch_q]) + (SB+18)'(fb);
		osum  = ((SB+18)'(oacc_q) + (SB+18)'(p_q) + (SB+18)'(1 << 13)) >>> 14;
	end

	// shared multiplier operands
	always_comb begin
		case (st_q)
			ST_IA: begin
				ma = MAW'(diff_l);
				mb = MBW'($signed({1'b0, frac_q}));
			end
			ST_IB: begin
				ma = MAW'(diff_r);
				mb = MBW'($signed({1'b0, frac_q}));
			end
			ST_F0: begin
				ma = hc_q ? MAW'(y_q) : MAW'(fbin);
				mb = MBW'(cb0);
			end
			ST_F2: begin
				ma = MAW'(y_q);
				mb = MBW'(ca1);
			end
			ST_F3: begin
				ma = MAW'(y_q);
				mb = MBW'(ca2);
			end
			ST_D0: begin
				ma = $signed({1'b0, ymag});
				mb = MBW'($signed({1'b0, cfg.drive_gain}));
			end
			ST_D1: begin
				ma = MAW'($signed({1'b0, tnext - sfd_pkg::tanh_lut(tidx)}));
				mb = MBW'($signed({1'b0, f16}));
			end
			ST_D2: begin
				ma = MAW'($signed({1'b0, tval}));
				mb = MBW'($signed({1'b0, gcap}));
			end
			ST_D3: begin
				ma = MAW'(x_q[ch_q]);
				mb = MBW'($signed({1'b0, cfg.dry_gain}));
			end
			ST_D4: begin
				ma = MAW'(d_q[ch_q]);
				mb = MBW'($signed({1'b0, cfg.wet_gain}));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= ma * mb;
	end

	assign out_free  = !ov_q || result.ready;
	assign feed.ready = (st_q == ST_IDLE);
	assign mem_raddr = (st_q == ST_RDA) ? ra_q : rb_q;
	assign mem_wen   = (st_q == ST_WR) && out_free;
	assign mem_wdata = {wr_q[1], wr_q[0]};

	// datapath words, no reset needed
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q[0] <= feed.left_in;
				x_q[1] <= feed.right_in;
				ra_q   <= ra_n;
				rb_q   <= rb_n;
				frac_q <= dtc[FRAC_BITS-1:0];
			end
			ST_RDB: begin
				a_q[0] <= rd_l;
				a_q[1] <= rd_r;
			end
			ST_IA: bR_q <= rd_r;
			ST_IB: d_q[0] <= SB'(PW'(a_q[0]) + (p_q >>> FRAC_BITS));
			ST_IC: d_q[1] <= SB'(PW'(a_q[1]) + (p_q >>> FRAC_BITS));
			ST_F1: begin
				bx_q <= (COEF_BITS+33)'(p_q);
				y_q  <= acc_rs;
			end
			ST_D1: begin
				t0_q   <= sfd_pkg::tanh_lut(tidx);
				tsat_q <= tover;
			end
			ST_D3: wr_q[ch_q] <= satsb(wsum);
			ST_D4: oacc_q <= (SB+17)'(p_q);
			ST_D5: o_q[ch_q] <= satsb(osum);
			ST_WR: begin
				if (out_free) begin
					lout_q <= o_q[0];
					rout_q <= o_q[1];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ch_q <= 1'b0;
			hc_q <= 1'b0;
			ov_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				ls1_q[i] <= '0;
				ls2_q[i] <= '0;
				hs1_q[i] <= '0;
				hs2_q[i] <= '0;
			end
		end else begin
			// a new word may replace the one being taken in the same cycle
			if ((st_q == ST_WR) && out_free) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (feed.valid) begin
						st_q <= ST_RDA;
					end
				end
				ST_RDA: st_q <= ST_RDB;
				ST_RDB: st_q <= ST_IA;
				ST_IA:  st_q <= ST_IB;
				ST_IB:  st_q <= ST_IC;
				ST_IC: begin
					ch_q <= 1'b0;
					hc_q <= 1'b0;
					st_q <= ST_F0;
				end
				ST_F0: st_q <= ST_F1;
				ST_F1: st_q <= ST_F2;
				ST_F2: st_q <= ST_F3;
				ST_F3: begin
					if (hc_q) begin
						hs1_q[ch_q] <= acc_rs;
					end else begin
						ls1_q[ch_q] <= acc_rs;
					end
					st_q <= ST_F4;
				end
				ST_F4: begin
					if (hc_q) begin
						hs2_q[ch_q] <= acc_rs;
						st_q        <= ST_D0;
					end else begin
						ls2_q[ch_q] <= acc_rs;
						hc_q        <= 1'b1;
						st_q        <= ST_F0;
					end
				end
				ST_D0: st_q <= ST_D1;
				ST_D1: st_q <= ST_D2;
				ST_D2: st_q <= ST_D3;
				ST_D3: st_q <= ST_D4;
				ST_D4: st_q <= ST_D5;
				ST_D5: begin
					if (ch_q) begin
						st_q <= ST_WR;
					end else begin
						ch_q <= 1'b1;
						hc_q <= 1'b0;
						st_q <= ST_F0;
					end
				end
				ST_WR: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid     = ov_q;
	assign result.left_out  = lout_q;
	assign result.right_out = rout_q;
endmodule

### sv/stereo_feedback_delay.sv
// Stereo feedback (ping-pong) delay: one stereo word in, one stereo word out.
// Channels: feed takes a word when valid and ready are both high; result offers
// the processed word under valid/ready and holds it until it is taken.
// Settings are to be written over the APB port only while the block is idle; the block itself does not enforce this.
// A new word is taken only in the idle state, once the previous one is written back.
// A single multiplier is shared by all multiplications (interpolation, two biquads
// per channel, drive, gains) and the sequencer walks them one per cycle, plus one
// delay-memory read per tap.
// A new word is accepted while the previous result still waits; the write-back
// step waits for the output register to free, so a stalled receiver holds the
// block after at most one further word.
// Reset clears the sequencer, filter states, write pointer and fill mark;
// memory entries not yet written read as zero, so no clearing pass is needed.
// Depends on sfd_pkg, sfd_ifs, sfd_regs, sfd_dmem and sfd_core.
module stereo_feedback_delay #(
	parameter int DELAY_DEPTH = 131072,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 21,
	parameter int FRAC_BITS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	sfd_in_if.sink      feed,
	sfd_out_if.source   result
);
	localparam int AW = $clog2(DELAY_DEPTH);

	sfd_pkg::cfg_t            cfg;
	logic [AW-1:0]            raddr;
	logic [2*SAMPLE_BITS-1:0] rdata;
	logic                     wen;
	logic [2*SAMPLE_BITS-1:0] wdata;
	logic [AW-1:0]            wptr;

	sfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfd_dmem #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.rdata  (rdata),
		.wen    (wen),
		.wdata  (wdata),
		.wptr   (wptr)
	);

	sfd_core #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.AW          (AW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.feed      (feed),
		.result    (result),
		.mem_raddr (raddr),
		.mem_rdata (rdata),
		.mem_wen   (wen),
		.mem_wdata (wdata),
		.mem_wptr  (wptr)
	);
endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the stereo feedback delay: APB set-up, stereo word stream in and out.
// Depends on sfd_pkg, sfd_ifs and the stereo_feedback_delay top level.
module tb_top;

	localparam int DEPTH     = 131072;
	localparam int SBITS     = 24;
	localparam int CBITS     = 21;
	localparam int FBITS     = 8;
	localparam int LIMIT     = 1000000;
	localparam int SETTLE    = 100;

	typedef struct {
		logic signed [SBITS-1:0] left;
		logic signed [SBITS-1:0] right;
	} pair_t;

	localparam int TANH_Q15 [0:32] = '{
		0, 4075, 8026, 11743, 15143, 18173, 20813, 23066,
		24956, 26519, 27796, 28830, 29660, 30322, 30847, 31262,
		31589, 31846, 32048, 32206, 32329, 32426, 32501, 32560,
		32606, 32642, 32670, 32691, 32708, 32721, 32732, 32740,
		32746
	};

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	sfd_in_if  #(.SAMPLE_BITS(SBITS)) feed_if ();
	sfd_out_if #(.SAMPLE_BITS(SBITS)) out_if ();

	stereo_feedback_delay dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.feed(feed_if), .result(out_if)
	);

	// shadow of the block's settings and state
	sfd_pkg::cfg_t           shadow;
	logic signed [SBITS-1:0] tap_l [DEPTH];
	logic signed [SBITS-1:0] tap_r [DEPTH];
	int unsigned             wr_ptr;
	int                      lc_st [4];
	int                      hc_st [4];

	pair_t pending_pairs [$];
	int    errors;
	int    words_sent;
	int    words_checked;
	int    cycle_count;
	int    settings_used;
	bit    quiet_sender;
	bit    quiet_receiver;

	initial begin
		clk = 1'b0;
		cycle_count = 0;
		forever begin
			#10 clk = 1'b1;
			cycle_count++;
			if (cycle_count > LIMIT) begin
				$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
					pending_pairs.size());
				$display("*** FAILED ***");
				$finish;
			end
			#10 clk = 1'b0;
		end
	end

	function automatic longint clip(longint v, int bits);
		longint hi, lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint coef_of(logic [63:0] c, int k);
		logic signed [CBITS-1:0] f;
		f = c[k*CBITS +: CBITS];
		return longint'(f);
	endfunction

	// transposed direct form II; b1 = sgn * 2 * b0, b2 = b0
	function automatic longint biquad(longint x, logic [63:0] c, int sgn,
			inout int s1, inout int s2);
		longint b0, a1, a2, y, n1, n2;
		b0 = coef_of(c, 0);
		a1 = coef_of(c, 1);
		a2 = coef_of(c, 2);
		y  = clip(round_shift(b0 * x + (longint'(s1) <<< (CBITS - 2)), CBITS - 2), 32);
		n1 = clip(round_shift(sgn * 2 * b0 * x - a1 * y + (longint'(s2) <<< (CBITS - 2)),
			CBITS - 2), 32);
		n2 = clip(round_shift(b0 * x - a2 * y, CBITS - 2), 32);
		s1 = int'(n1);
		s2 = int'(n2);
		return y;
	endfunction

	function automatic longint drive_feedback(longint y);
		longint m, pos, idx, t, g, fb;
		m   = (y < 0 ? -y : y) * longint'(shadow.drive_gain);
		pos = m >> (SBITS - 8);
		idx = pos >> 16;
		if (idx >= 32)
			t = TANH_Q15[32];
		else
			t = TANH_Q15[idx] + (((TANH_Q15[idx+1] - TANH_Q15[idx]) * (pos & 16'hFFFF)) >> 16);
		g  = shadow.feedback_gain > sfd_pkg::FEEDBACK_CAP ? sfd_pkg::FEEDBACK_CAP
			: shadow.feedback_gain;
		fb = (((t * g) << (SBITS - 1)) + (64'sd1 <<< 29)) >> 30;
		return y < 0 ? -fb : fb;
	endfunction

	function automatic pair_t compute_echo(logic signed [SBITS-1:0] xl,
			logic signed [SBITS-1:0] xr);
		longint      dt, frac, a, b, y, o;
		longint      dly [2];
		longint      fbin [2];
		longint      x [2];
		int unsigned dint, ra, rb;
		pair_t       res;
		dt = shadow.delay_time;
		if (dt < (1 << FBITS)) dt = 1 << FBITS;
		if (dt > (longint'(DEPTH - 1) << FBITS)) dt = longint'(DEPTH - 1) << FBITS;
		dint = int'(dt >> FBITS);
		frac = dt & ((1 << FBITS) - 1);
		ra = (wr_ptr + DEPTH - dint) % DEPTH;
		rb = (ra + DEPTH - 1) % DEPTH;
		for (int c = 0; c < 2; c++) begin
			a = c == 0 ? tap_l[ra] : tap_r[ra];
			b = c == 0 ? tap_l[rb] : tap_r[rb];
			dly[c] = a + (((b - a) * frac) >>> FBITS);
		end
		fbin[0] = shadow.ping_pong ? dly[1] : dly[0];
		fbin[1] = shadow.ping_pong ? dly[0] : dly[1];
		x[0] = xl;
		x[1] = xr;
		for (int c = 0; c < 2; c++) begin
			y = biquad(fbin[c], shadow.lowcut_coeffs, -1, lc_st[2*c], lc_st[2*c+1]);
			y = biquad(y, shadow.highcut_coeffs, 1, hc_st[2*c], hc_st[2*c+1]);
			a = clip(x[c] + drive_feedback(y), SBITS);
			o = clip(round_shift(x[c] * longint'(shadow.dry_gain)
				+ dly[c] * longint'(shadow.wet_gain), 14), SBITS);
			if (c == 0) begin
				tap_l[wr_ptr] = a[SBITS-1:0];
				res.left = o[SBITS-1:0];
			end else begin
				tap_r[wr_ptr] = a[SBITS-1:0];
				res.right = o[SBITS-1:0];
			end
		end
		wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on word %0d, %s: got %0d, expected %0d", words_checked, what, got,
			want);
		errors++;
	endtask

	task automatic reg_write(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (idx)
			sfd_pkg::REG_DELAY_TIME:    shadow.delay_time     = val[24:0];
			sfd_pkg::REG_FEEDBACK_GAIN: shadow.feedback_gain  = val[14:0];
			sfd_pkg::REG_DRY_GAIN:      shadow.dry_gain       = val[14:0];
			sfd_pkg::REG_WET_GAIN:      shadow.wet_gain       = val[14:0];
			sfd_pkg::REG_DRIVE_GAIN:    shadow.drive_gain     = val[15:0];
			sfd_pkg::REG_PING_PONG:     shadow.ping_pong      = val[0];
			sfd_pkg::REG_LOWCUT:        shadow.lowcut_coeffs  = val;
			default:                    shadow.highcut_coeffs = val;
		endcase
	endtask

	task automatic wait_idle();
		@(negedge clk);
		feed_if.valid = 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// feed one stereo word; valid is left high so back-to-back words need no drop
	task automatic send_word(logic signed [SBITS-1:0] l, logic signed [SBITS-1:0] r);
		int gap;
		gap = quiet_sender ? 0 : pick_gap();
		@(negedge clk);
		repeat (gap) begin
			feed_if.valid = 1'b0;
			@(negedge clk);
		end
		feed_if.valid    = 1'b1;
		feed_if.left_in  = l;
		feed_if.right_in = r;
		do @(posedge clk); while (!feed_if.ready);
		pending_pairs.push_back(compute_echo(l, r));
		words_sent++;
	endtask

	function automatic logic [63:0] tame_coeffs();
		logic [20:0] b0, a1, a2;
		b0 = 21'($urandom_range(0, 1 << 19));
		a1 = 21'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		a2 = 21'($urandom_range(0, 1 << 18));
		return {1'b0, a2, a1, b0};
	endfunction

	task automatic random_settings(bit wild);
		reg_write(sfd_pkg::REG_DELAY_TIME,
			wild ? 64'($urandom) : 64'($urandom_range(0, 40 * 256)));
		reg_write(sfd_pkg::REG_FEEDBACK_GAIN, 64'($urandom_range(0, 32767)));
		reg_write(sfd_pkg::REG_DRY_GAIN, 64'($urandom_range(0, 32767)));
		reg_write(sfd_pkg::REG_WET_GAIN, 64'($urandom_range(0, 32767)));
		reg_write(sfd_pkg::REG_DRIVE_GAIN, 64'($urandom_range(0, 65535)));
		reg_write(sfd_pkg::REG_PING_PONG, 64'($urandom_range(0, 1)));
		reg_write(sfd_pkg::REG_LOWCUT, wild ? {$urandom, $urandom} : tame_coeffs());
		reg_write(sfd_pkg::REG_HIGHCUT, wild ? {$urandom, $urandom} : tame_coeffs());
		settings_used++;
	endtask

	task automatic test_extremes();
		logic signed [SBITS-1:0] top, bot;
		top = {1'b0, {(SBITS-1){1'b1}}};
		bot = {1'b1, {(SBITS-1){1'b0}}};
		quiet_sender = 1'b1;
		// delay below one sample, gain above the cap, full drive, swap on
		reg_write(sfd_pkg::REG_DELAY_TIME, 64'd0);
		reg_write(sfd_pkg::REG_FEEDBACK_GAIN, 64'd32767);
		reg_write(sfd_pkg::REG_DRY_GAIN, 64'd32767);
		reg_write(sfd_pkg::REG_WET_GAIN, 64'd32767);
		reg_write(sfd_pkg::REG_DRIVE_GAIN, 64'd65535);
		reg_write(sfd_pkg::REG_PING_PONG, 64'd1);
		reg_write(sfd_pkg::REG_LOWCUT, {1'b0, 21'd0, 21'd0, 21'd524288});
		reg_write(sfd_pkg::REG_HIGHCUT, {1'b0, 21'd0, 21'd0, 21'd131072});
		settings_used++;
		send_word(top, bot);
		send_word(bot, top);
		send_word(top, top);
		send_word(bot, bot);
		send_word('0, '0);
		send_word('1, '0);
		send_word(24'sh555555, 24'shAAAAAA);
		send_word(24'shAAAAAA, 24'sh555555);
		send_word('0, '0);
		send_word('0, '0);
		wait_idle();
		// delay past the end of the memory, feedback and wet gains at zero
		reg_write(sfd_pkg::REG_DELAY_TIME, 64'h1FF_FFFF);
		reg_write(sfd_pkg::REG_FEEDBACK_GAIN, 64'd0);
		reg_write(sfd_pkg::REG_WET_GAIN, 64'd0);
		reg_write(sfd_pkg::REG_DRIVE_GAIN, 64'd4096);
		reg_write(sfd_pkg::REG_PING_PONG, 64'd0);
		settings_used++;
		send_word(top, bot);
		send_word(bot, top);
		send_word(24'sd1, -24'sd1);
		wait_idle();
		// one-and-a-half-sample delay with hot filters so the states saturate
		reg_write(sfd_pkg::REG_DELAY_TIME, 64'd384);
		reg_write(sfd_pkg::REG_FEEDBACK_GAIN, 64'd31129);
		reg_write(sfd_pkg::REG_WET_GAIN, 64'd16384);
		reg_write(sfd_pkg::REG_LOWCUT, {1'b0, 21'h100000, 21'h0FFFFF, 21'h0FFFFF});
		reg_write(sfd_pkg::REG_HIGHCUT, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF});
		settings_used++;
		repeat (6) send_word(top, bot);
		send_word(bot, top);
		wait_idle();
		quiet_sender = 1'b0;
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 8; phase++) begin
			random_settings(phase == 3 || phase == 6);
			quiet_sender   = (phase == 2);
			quiet_receiver = (phase == 2 || phase == 5);
			repeat (150) send_word(24'($urandom), 24'($urandom));
			wait_idle();
		end
		quiet_sender   = 1'b0;
		quiet_receiver = 1'b0;
	endtask

	// result side: random stalls, compare each word with the oldest prediction
	initial begin
		pair_t want;
		int    stall;
		out_if.ready = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_if.valid && out_if.ready) begin
				if (pending_pairs.size() == 0) begin
					$display("unexpected word: %0d %0d", out_if.left_out, out_if.right_out);
					errors++;
				end else begin
					want = pending_pairs.pop_front();
					if (out_if.left_out !== want.left)
						report_mismatch("left_out", out_if.left_out, want.left);
					if (out_if.right_out !== want.right)
						report_mismatch("right_out", out_if.right_out, want.right);
				end
				words_checked++;
			end
			@(negedge clk);
			if (quiet_receiver) begin
				out_if.ready = 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_if.ready = 1'b0;
			end else begin
				stall = pick_gap();
				out_if.ready = (stall == 0);
			end
		end
	end

	initial begin
		int drain;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		feed_if.valid = 1'b0; feed_if.left_in = '0; feed_if.right_in = '0;
		errors = 0; words_sent = 0; words_checked = 0; settings_used = 1;
		quiet_sender = 1'b0; quiet_receiver = 1'b0;
		shadow = '{sfd_pkg::RST_DELAY_TIME, sfd_pkg::RST_FEEDBACK_GAIN,
			sfd_pkg::RST_DRY_GAIN, sfd_pkg::RST_WET_GAIN,
			sfd_pkg::RST_DRIVE_GAIN, 1'b0, 64'd0, 64'd0};
		for (int i = 0; i < DEPTH; i++) begin
			tap_l[i] = '0;
			tap_r[i] = '0;
		end
		wr_ptr = 0;
		lc_st = '{default: 0};
		hc_st = '{default: 0};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (20) send_word(24'($urandom), 24'($urandom));
		wait_idle();
		test_extremes();
		test_random();
		feed_if.valid = 1'b0;
		drain = 0;
		while (pending_pairs.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_pairs.size() != 0) begin
			$display("%0d predicted words never came out", pending_pairs.size());
			errors++;
		end
		$display("sent %0d stereo words, checked %0d, under %0d register settings",
			words_sent, words_checked, settings_used);
		$display("mismatches: %0d", errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
sv/sfd_pkg.sv
sv/sfd_ifs.sv
sv/sfd_regs.sv
sv/sfd_dmem.sv
sv/sfd_core.sv
sv/stereo_feedback_delay.sv
tb/sv/tb_top.sv
